/* src/bgbc_pkg.sv */
// shared types and constants for the bit granular block copy
package bgbc_pkg;
   localparam int BufBytes = 256;
   localparam int AddrW = 8;
   localparam int StoreBits = BufBytes * 8;
   localparam int MaxFieldBits = 32;

   typedef enum logic [2:0] {
      OP_WR_SRC = 3'd0,
      OP_WR_DST = 3'd1,
      OP_RD_DST = 3'd2,
      OP_COPY   = 3'd3,
      OP_EXTR   = 3'd4,
      OP_INS    = 3'd5,
      OP_BAD6   = 3'd6,
      OP_BAD7   = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  byte_addr;
      logic [7:0]  byte_data;
      logic [10:0] src_bit_pos;
      logic [11:0] src_bits_left;
      logic [10:0] dst_bit_pos;
      logic [11:0] dst_bits_left;
      logic [11:0] bit_count;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_byte;
      logic [31:0] value_out;
      logic        ok;
      logic [11:0] src_bit_pos_after;
      logic [11:0] src_bits_left_after;
      logic [11:0] dst_bit_pos_after;
      logic [11:0] dst_bits_left_after;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture request
      logic fetch;     // read the bytes under both cursors
      logic step;      // move one bit
      logic finish;    // latch result
   } cmd_type;

   typedef struct packed {
      logic simple;    // byte op, empty copy or rejected, no bit steps
      logic last;      // final bit step
   } sts_type;
endpackage

/* src/bgbc_datapath.sv */
// stores, cursors and bit mover of the block copy
module bgbc_datapath
   import bgbc_pkg::*;
(
   input  logic    clock,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);
   logic [7:0] src_mem [BufBytes];
   logic [7:0] dst_mem [BufBytes];

   req_type     r_ff;
   logic [11:0] cnt_ff, cnt_in;
   logic [11:0] sp_ff, dp_ff;
   logic [31:0] acc_ff;
   logic        okv_ff;
   rsp_type     rsp_ff;
   logic [7:0]  sbyte_ff, dbyte_ff;

   // checks on the incoming request
   logic [12:0] s_end, d_end;
   logic        len_ok, s_ok, d_ok, acc;
   logic [11:0] n;
   assign n     = req.bit_count;
   assign s_end = 13'(req.src_bit_pos) + 13'(n);
   assign d_end = 13'(req.dst_bit_pos) + 13'(n);
   assign s_ok  = (n <= req.src_bits_left) && (s_end <= 13'(StoreBits));
   assign d_ok  = (n <= req.dst_bits_left) && (d_end <= 13'(StoreBits));
   assign len_ok = (n != 12'd0) && (n <= 12'(MaxFieldBits));
   always_comb begin
      case (op_type'(req.op))
         OP_COPY: acc = s_ok && d_ok;
         OP_EXTR: acc = len_ok && s_ok;
         OP_INS:  acc = len_ok && d_ok;
         default: acc = 1'b0;
      endcase
   end
   assign sts.simple = !acc || (n == 12'd0);

   // bit move: read source bit or, for insert, value bit; write destination bit unless extracting
   logic       sbit, wbit;
   logic [7:0] mask;
   logic [7:0] sidx, didx;
   assign sidx  = sp_ff[10:3];
   assign didx  = dp_ff[10:3];
   assign sbit  = sbyte_ff[3'd7 - sp_ff[2:0]];
   assign mask  = 8'h80 >> dp_ff[2:0];
   assign cnt_in = cnt_ff - 12'd1;
   always_comb begin
      if (op_type'(r_ff.op) == OP_INS) wbit = r_ff.value_in[cnt_in[4:0]];
      else wbit = sbit;
   end
   assign sts.last = (cnt_ff == 12'd1);

   logic okb;
   assign okb = 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff   <= req;
         cnt_ff <= n;
         sp_ff  <= 12'(req.src_bit_pos);
         dp_ff  <= 12'(req.dst_bit_pos);
         acc_ff <= '0;
         okv_ff <= acc;
         if (op_type'(req.op) == OP_WR_SRC) src_mem[req.byte_addr] <= req.byte_data;
         if (op_type'(req.op) == OP_WR_DST) dst_mem[req.byte_addr] <= req.byte_data;
         if (sts.simple) begin
            rsp_ff.read_byte <= (op_type'(req.op) == OP_RD_DST) ?
                                dst_mem[req.byte_addr] : 8'd0;
            rsp_ff.value_out <= '0;
            rsp_ff.ok <= acc || (req.op <= 3'd2);
            rsp_ff.src_bit_pos_after   <= 12'(req.src_bit_pos);
            rsp_ff.src_bits_left_after <= req.src_bits_left;
            rsp_ff.dst_bit_pos_after   <= 12'(req.dst_bit_pos);
            rsp_ff.dst_bits_left_after <= req.dst_bits_left;
         end
      end else if (cmd.fetch) begin
         sbyte_ff <= src_mem[sidx];
         dbyte_ff <= dst_mem[didx];
      end else if (cmd.step) begin
         cnt_ff <= cnt_in;
         sp_ff  <= sp_ff + 12'd1;
         dp_ff  <= dp_ff + 12'd1;
         acc_ff <= {acc_ff[30:0], sbit};
         if (op_type'(r_ff.op) != OP_EXTR)
            dst_mem[didx] <= wbit ? (dbyte_ff | mask) : (dbyte_ff & ~mask);
      end else if (cmd.finish) begin
         rsp_ff.read_byte <= '0;
         rsp_ff.value_out <= (op_type'(r_ff.op) == OP_EXTR) ? acc_ff : '0;
         rsp_ff.ok <= okv_ff & okb;
         if (op_type'(r_ff.op) != OP_INS) begin
            rsp_ff.src_bit_pos_after   <= 12'(r_ff.src_bit_pos) + r_ff.bit_count;
            rsp_ff.src_bits_left_after <= r_ff.src_bits_left - r_ff.bit_count;
         end else begin
            rsp_ff.src_bit_pos_after   <= 12'(r_ff.src_bit_pos);
            rsp_ff.src_bits_left_after <= r_ff.src_bits_left;
         end
         if (op_type'(r_ff.op) != OP_EXTR) begin
            rsp_ff.dst_bit_pos_after   <= 12'(r_ff.dst_bit_pos) + r_ff.bit_count;
            rsp_ff.dst_bits_left_after <= r_ff.dst_bits_left - r_ff.bit_count;
         end else begin
            rsp_ff.dst_bit_pos_after   <= 12'(r_ff.dst_bit_pos);
            rsp_ff.dst_bits_left_after <= r_ff.dst_bits_left;
         end
      end
   end
   assign rsp = rsp_ff;
endmodule

/* src/bgbc_ctrl.sv */
// sequencer of the block copy
module bgbc_ctrl
   import bgbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_valid
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_STEP  = 5'b00100,
      ST_FIN   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      go;
   assign go = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start) state_in = sts.simple ? ST_OUT : ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = sts.last ? ST_FIN : ST_FETCH;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
   assign busy = (state_ff != ST_IDLE) && !go;
   assign rsp_valid = (state_ff == ST_OUT);
endmodule

/* src/bit_granular_block_copy.sv */
// top level of the bit granular block copy
// one item is taken when start is high and busy low; its result appears on
// rsp_ for one cycle with rsp_valid and cannot be held off. byte writes,
// byte reads, empty copies and rejected items go from the load straight to
// the result state; copy, extract and insert pass each bit through the
// single bit mover: a fetch reads the bytes under both cursors from the
// stores, a step advances the cursors and, but for extract, writes back
// the merged destination byte; a finish then latches the result. busy
// stays high until the result cycle is over, then the next item may start.
module bit_granular_block_copy
   import bgbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);
   cmd_type cmd;
   sts_type sts;

   // sequencer
   bgbc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts),
      .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   // stores and bit mover
   bgbc_datapath u_dp (
      .clock(clock), .req(req_item), .cmd(cmd), .sts(sts), .rsp(rsp_item)
   );
endmodule

/* src/bgbc_checker.sv */
// port level checks of the block copy
module bgbc_checker
   import bgbc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_busy_res: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("not busy during result");
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("item taken but not busy");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.ok |-> rsp_item.value_out == 32'd0)
      else $error("value on rejected item");
endmodule

bind bit_granular_block_copy bgbc_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_item(rsp_item)
);
